// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bis_pkg.sv =====
package bis_pkg;

  // Fixed-point format and size limits.
  localparam int FRAC_BITS      = 8;
  localparam int MAX_SRC_WIDTH  = 128;
  localparam int MAX_SRC_HEIGHT = 128;
  localparam int MAX_DST        = 1024;

  localparam int FRAC_ONE  = 2 ** FRAC_BITS;
  localparam int FRAC_HALF = FRAC_ONE / 2;

  // Field and register widths.
  localparam int PIX_W      = 8;
  localparam int SRC_CFG_W  = 8;
  localparam int DST_CFG_W  = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_ADDR_W = 2;

  // Internal widths derived from the limits.
  localparam int SW_W    = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SH_W    = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int COL_W   = $clog2(MAX_SRC_WIDTH);
  localparam int ROW_W   = $clog2(MAX_SRC_HEIGHT);
  localparam int DW_W    = $clog2(MAX_DST + 1);
  localparam int IDX_W   = $clog2(MAX_DST);
  localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
  localparam int STEP_W  = ((SW_W > SH_W) ? SW_W : SH_W) + FRAC_BITS;
  localparam int POS_W   = STEP_W + IDX_W;
  localparam int DIV_CNT_W = $clog2(STEP_W + 1);
  localparam int WGT_W   = FRAC_BITS + 1;
  localparam int VERT_W  = PIX_W + WGT_W;
  localparam int ACC_W   = VERT_W + WGT_W;

  // Request kinds carried on the input tuser bit.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DST_HEIGHT = 2'd3;

  // Four neighbors and the two fractions of one output pixel.
  typedef struct packed {
    logic [PIX_W-1:0]     p00;
    logic [PIX_W-1:0]     p01;
    logic [PIX_W-1:0]     p10;
    logic [PIX_W-1:0]     p11;
    logic [FRAC_BITS-1:0] rx;
    logic [FRAC_BITS-1:0] ry;
  } interp_req_t;

endpackage

// ===== rtl/bis_frame_ram.sv =====
module bis_frame_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [bis_pkg::ADDR_W-1:0] waddr,
  input  logic [bis_pkg::PIX_W-1:0]  wdata,
  input  logic [bis_pkg::ADDR_W-1:0] raddr_a,
  input  logic [bis_pkg::ADDR_W-1:0] raddr_b,
  output logic [bis_pkg::PIX_W-1:0]  rdata_a,
  output logic [bis_pkg::PIX_W-1:0]  rdata_b
);
  import bis_pkg::*;

  logic [PIX_W-1:0] store_mem [STORE_DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[waddr] <= wdata;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    rdata_a <= store_mem[raddr_a];
    rdata_b <= store_mem[raddr_b];
  end

endmodule

// ===== rtl/bis_div.sv =====
module bis_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bis_pkg::STEP_W-1:0] dividend,
  input  logic [bis_pkg::DW_W-1:0]   divisor,
  output logic                       done,
  output logic [bis_pkg::STEP_W-1:0] quotient
);
  import bis_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DW_W-1:0]      div_r;
  logic [DW_W-1:0]      rem_r;
  logic [STEP_W-1:0]    quo_r;
  logic [DW_W:0]        trial;
  logic                 fits;
  logic [DW_W:0]        diff;

  // One restoring step: bring down the next dividend bit and try to subtract.
  assign trial = {rem_r, quo_r[STEP_W-1]};
  assign fits  = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(STEP_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DW_W-1:0] : trial[DW_W-1:0];
      quo_r <= {quo_r[STEP_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/bis_interp.sv =====
module bis_interp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  bis_pkg::interp_req_t        req,
  output logic                        done,
  output logic [bis_pkg::PIX_W-1:0]   pixel
);
  import bis_pkg::*;

  logic              s1_vld_r;
  logic              s2_vld_r;
  logic              done_r;
  logic [VERT_W-1:0] v0_r;
  logic [VERT_W-1:0] v1_r;
  logic [FRAC_BITS-1:0] ry_r;
  logic [ACC_W-1:0]  acc_r;
  logic [PIX_W-1:0]  pixel_r;

  logic [WGT_W-1:0]  wx_lo;
  logic [WGT_W-1:0]  wx_hi;
  logic [WGT_W-1:0]  wy_lo;
  logic [WGT_W-1:0]  wy_hi;
  logic [ACC_W-2*FRAC_BITS-1:0] pix_int;
  logic [ACC_W-2*FRAC_BITS-1:0] pix_rnd;
  logic              round_up;

  // Weights of the two rows and the two columns.
  assign wx_hi = WGT_W'(req.rx);
  assign wx_lo = WGT_W'(FRAC_ONE) - wx_hi;
  assign wy_hi = WGT_W'(ry_r);
  assign wy_lo = WGT_W'(FRAC_ONE) - wy_hi;

  // Round up only when the residual is above one half, then saturate.
  assign pix_int  = acc_r[ACC_W-1:2*FRAC_BITS];
  assign round_up = acc_r[2*FRAC_BITS-1:FRAC_BITS] > FRAC_BITS'(FRAC_HALF);
  assign pix_rnd  = pix_int + (ACC_W-2*FRAC_BITS)'(round_up);

  // Pipeline valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      s1_vld_r <= start;
      s2_vld_r <= s1_vld_r;
      done_r   <= s2_vld_r;
    end
  end

  // Stage one blends vertically, stage two horizontally, stage three rounds.
  always_ff @(posedge clk) begin
    if (start) begin
      v0_r <= VERT_W'(req.p00) * VERT_W'(wx_lo) + VERT_W'(req.p10) * VERT_W'(wx_hi);
      v1_r <= VERT_W'(req.p01) * VERT_W'(wx_lo) + VERT_W'(req.p11) * VERT_W'(wx_hi);
      ry_r <= req.ry;
    end
    if (s1_vld_r) begin
      acc_r <= ACC_W'(v0_r) * ACC_W'(wy_lo) + ACC_W'(v1_r) * ACC_W'(wy_hi);
    end
    if (s2_vld_r) begin
      pixel_r <= (pix_rnd > (ACC_W-2*FRAC_BITS)'(2**PIX_W - 1)) ?
                 {PIX_W{1'b1}} : pix_rnd[PIX_W-1:0];
    end
  end

  assign done  = done_r;
  assign pixel = pixel_r;

endmodule

// ===== rtl/bilinear_image_scaler.sv =====
// Bilinear image scaler. Send one 8-bit image as load requests (in_tuser low) in
// raster order; once src_width*src_height pixels are held, each fetch request
// (in_tuser high) returns the next scaled pixel in raster order, with out_tlast
// marking the end of an output row and out_tuser the last pixel of the frame.
// After that pixel the frame store counts as empty and the next image must be
// loaded. Loads past a full frame and fetches before one produce nothing. A fetch
// runs the two neighbor-row reads through the two read ports of the frame memory
// and the three-stage multiply and round pipeline, and no new request is taken
// until its pixel enters the output register; the first fetch of a frame first
// runs the bit-serial division that forms the row and column steps. Sizes are
// clamped to 1..128 for the source and 1..1024 for the destination; write them
// between requests only.
module bilinear_image_scaler (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input requests.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bis_pkg::PIX_W-1:0]         in_tdata,   // [7:0] pixel_in
  input  logic                              in_tuser,   // [0] op
  // Output pixels.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bis_pkg::PIX_W-1:0]         out_tdata,  // [7:0] pixel_out
  output logic                              out_tlast,  // row_end
  output logic                              out_tuser,  // [0] frame_end
  // Configuration writes.
  input  logic                              cfg_we,
  input  logic [bis_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bis_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bis_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DIV    = 8'b0000_0010,
    ST_ADDR   = 8'b0000_0100,
    ST_RD0    = 8'b0000_1000,
    ST_RD1    = 8'b0001_0000,
    ST_RD2    = 8'b0010_0000,
    ST_INTERP = 8'b0100_0000,
    ST_FIN    = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Configuration registers.
  logic [SRC_CFG_W-1:0] src_width_r;
  logic [SRC_CFG_W-1:0] src_height_r;
  logic [DST_CFG_W-1:0] dst_width_r;
  logic [DST_CFG_W-1:0] dst_height_r;

  // Frame progress.
  logic [CNT_W-1:0]  load_cnt_r;
  logic [IDX_W-1:0]  out_row_r;
  logic [IDX_W-1:0]  out_col_r;
  logic [POS_W-1:0]  row_pos_r;
  logic [POS_W-1:0]  col_pos_r;
  logic [STEP_W-1:0] row_step_r;
  logic [STEP_W-1:0] col_step_r;

  // Neighbor coordinates and fetched top row.
  logic [ROW_W-1:0]     r0_r;
  logic [ROW_W-1:0]     r1_r;
  logic [COL_W-1:0]     c0_r;
  logic [COL_W-1:0]     c1_r;
  logic [FRAC_BITS-1:0] rx_r;
  logic [FRAC_BITS-1:0] ry_r;
  logic [PIX_W-1:0]     p00_r;
  logic [PIX_W-1:0]     p01_r;

  // Output register.
  logic             out_tvalid_r;
  logic [PIX_W-1:0] out_tdata_r;
  logic             out_tlast_r;
  logic             out_tuser_r;

  logic [SW_W-1:0]  sw;
  logic [SH_W-1:0]  sh;
  logic [DW_W-1:0]  dw;
  logic [DW_W-1:0]  dh;
  logic [SW_W-1:0]  sw_m1;
  logic [SH_W-1:0]  sh_m1;
  logic [CNT_W-1:0] full;
  logic             in_acc;
  logic             frame_ready;
  logic             first_pix;
  logic             div_start;
  logic             load_go;
  logic             row_done;
  logic             col_done;
  logic [STEP_W-1:0] row_quo;
  logic [STEP_W-1:0] col_quo;
  logic [POS_W-FRAC_BITS-1:0] row_int;
  logic [POS_W-FRAC_BITS-1:0] col_int;
  logic [ROW_W-1:0] r0;
  logic [COL_W-1:0] c0;
  logic [ROW_W-1:0] row_sel;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] raddr_a;
  logic [ADDR_W-1:0] raddr_b;
  logic [PIX_W-1:0] rdata_a;
  logic [PIX_W-1:0] rdata_b;
  interp_req_t      ip_req;
  logic             ip_start;
  logic             ip_done;
  logic [PIX_W-1:0] ip_pixel;
  logic             out_free;
  logic             fin_go;
  logic             row_end;
  logic             frame_end;

  function automatic logic [SW_W-1:0] clamp_sw(input logic [SRC_CFG_W-1:0] v);
    if (v == '0) return SW_W'(1);
    if (int'(v) > MAX_SRC_WIDTH) return SW_W'(MAX_SRC_WIDTH);
    return SW_W'(v);
  endfunction

  function automatic logic [SH_W-1:0] clamp_sh(input logic [SRC_CFG_W-1:0] v);
    if (v == '0) return SH_W'(1);
    if (int'(v) > MAX_SRC_HEIGHT) return SH_W'(MAX_SRC_HEIGHT);
    return SH_W'(v);
  endfunction

  function automatic logic [DW_W-1:0] clamp_dst(input logic [DST_CFG_W-1:0] v);
    if (v == '0) return DW_W'(1);
    if (int'(v) > MAX_DST) return DW_W'(MAX_DST);
    return DW_W'(v);
  endfunction

  // Sizes in use and the frame fill level.
  assign sw    = clamp_sw(src_width_r);
  assign sh    = clamp_sh(src_height_r);
  assign dw    = clamp_dst(dst_width_r);
  assign dh    = clamp_dst(dst_height_r);
  assign sw_m1 = sw - 1'b1;
  assign sh_m1 = sh - 1'b1;
  assign full  = CNT_W'(sw) * CNT_W'(sh);

  // Request decode.
  assign in_tready   = (state_r == ST_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign frame_ready = (load_cnt_r >= full);
  assign first_pix   = (out_row_r == '0) && (out_col_r == '0);
  assign load_go     = in_acc && (in_tuser == OP_LOAD) && (load_cnt_r < full);
  assign div_start   = in_acc && (in_tuser == OP_FETCH) && frame_ready && first_pix;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_CFG_W'(128);
      src_height_r <= SRC_CFG_W'(128);
      dst_width_r  <= DST_CFG_W'(128);
      dst_height_r <= DST_CFG_W'(128);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata[SRC_CFG_W-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_wdata[SRC_CFG_W-1:0];
        CFG_DST_WIDTH:  dst_width_r  <= cfg_wdata[DST_CFG_W-1:0];
        CFG_DST_HEIGHT: dst_height_r <= cfg_wdata[DST_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Row and column steps: size * 2^F / destination size.
  bis_div u_row_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (STEP_W'({sh, {FRAC_BITS{1'b0}}})),
    .divisor  (dh),
    .done     (row_done),
    .quotient (row_quo)
  );

  bis_div u_col_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (STEP_W'({sw, {FRAC_BITS{1'b0}}})),
    .divisor  (dw),
    .done     (col_done),
    .quotient (col_quo)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == OP_FETCH) && frame_ready) begin
          state_nxt = first_pix ? ST_DIV : ST_ADDR;
        end
      end
      ST_DIV: begin
        if (row_done) begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR:   state_nxt = ST_RD0;
      ST_RD0:    state_nxt = ST_RD1;
      ST_RD1:    state_nxt = ST_RD2;
      ST_RD2:    state_nxt = ST_INTERP;
      ST_INTERP: begin
        if (ip_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Neighbor coordinates, clamped to the last row and column.
  assign row_int = row_pos_r[POS_W-1:FRAC_BITS];
  assign col_int = col_pos_r[POS_W-1:FRAC_BITS];
  assign r0 = (row_int > (POS_W-FRAC_BITS)'(sh_m1)) ? sh_m1[ROW_W-1:0] : row_int[ROW_W-1:0];
  assign c0 = (col_int > (POS_W-FRAC_BITS)'(sw_m1)) ? sw_m1[COL_W-1:0] : col_int[COL_W-1:0];

  always_ff @(posedge clk) begin
    if (state_r == ST_ADDR) begin
      r0_r <= r0;
      r1_r <= (SH_W'(r0) < sh_m1) ? ROW_W'(r0 + 1'b1) : r0;
      c0_r <= c0;
      c1_r <= (SW_W'(c0) < sw_m1) ? COL_W'(c0 + 1'b1) : c0;
      rx_r <= row_pos_r[FRAC_BITS-1:0];
      ry_r <= col_pos_r[FRAC_BITS-1:0];
    end
    if (state_r == ST_RD1) begin
      p00_r <= rdata_a;
      p01_r <= rdata_b;
    end
  end

  // Top row is read in RD0, bottom row in RD1.
  assign row_sel  = (state_r == ST_RD1) ? r1_r : r0_r;
  assign row_base = ADDR_W'(row_sel) * ADDR_W'(sw);
  assign raddr_a  = row_base + ADDR_W'(c0_r);
  assign raddr_b  = row_base + ADDR_W'(c1_r);

  bis_frame_ram u_frame_ram (
    .clk     (clk),
    .we      (load_go),
    .waddr   (load_cnt_r[ADDR_W-1:0]),
    .wdata   (in_tdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Blend the four neighbors.
  assign ip_start   = (state_r == ST_RD2);
  assign ip_req.p00 = p00_r;
  assign ip_req.p01 = p01_r;
  assign ip_req.p10 = rdata_a;
  assign ip_req.p11 = rdata_b;
  assign ip_req.rx  = rx_r;
  assign ip_req.ry  = ry_r;

  bis_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ip_start),
    .req   (ip_req),
    .done  (ip_done),
    .pixel (ip_pixel)
  );

  // Row and frame boundaries of the pixel being finished.
  assign out_free  = !out_tvalid_r || out_tready;
  assign fin_go    = (state_r == ST_FIN) && out_free;
  assign row_end   = (DW_W'(out_col_r) + DW_W'(1)) >= dw;
  assign frame_end = row_end && ((DW_W'(out_row_r) + DW_W'(1)) >= dh);

  // Control state and frame progress.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      load_cnt_r   <= '0;
      out_row_r    <= '0;
      out_col_r    <= '0;
      row_pos_r    <= '0;
      col_pos_r    <= '0;
      row_step_r   <= '0;
      col_step_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_go) begin
        load_cnt_r <= load_cnt_r + 1'b1;
      end
      if (div_start) begin
        row_pos_r <= '0;
        col_pos_r <= '0;
      end
      if ((state_r == ST_DIV) && row_done) begin
        row_step_r <= row_quo;
      end
      if ((state_r == ST_DIV) && col_done) begin
        col_step_r <= col_quo;
      end
      if (fin_go) begin
        if (frame_end) begin
          load_cnt_r <= '0;
          row_pos_r  <= '0;
          col_pos_r  <= '0;
          out_row_r  <= '0;
          out_col_r  <= '0;
        end else if (row_end) begin
          out_col_r <= '0;
          col_pos_r <= '0;
          out_row_r <= out_row_r + 1'b1;
          row_pos_r <= row_pos_r + POS_W'(row_step_r);
        end else begin
          out_col_r <= out_col_r + 1'b1;
          col_pos_r <= col_pos_r + POS_W'(col_step_r);
        end
      end
      if (fin_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_tdata_r <= ip_pixel;
      out_tlast_r <= row_end;
      out_tuser_r <= frame_end;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== rtl/bis_checker.sv =====
`include "assert_macros.svh"

module bis_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bis_pkg::PIX_W-1:0]      out_tdata,
  input logic                           out_tlast,
  input logic                           out_tuser
);
  import bis_pkg::*;

  // A stalled output pixel keeps its value.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "output changed while stalled")

  // The last pixel of a frame also ends its row.
  `ASSERT_IMPLY(a_frame_ends_row, clk, rst_n, out_tvalid && out_tuser, out_tlast, "frame end without row end")

  // A load request never produces an output pixel.
  `ASSERT_NEXT(a_load_silent, clk, rst_n, in_tvalid && in_tready && (in_tuser == OP_LOAD) && !out_tvalid, !out_tvalid, "output after a load request")

  // A new pixel only appears after the block was busy on a fetch.
  `ASSERT_IMPLY(a_out_after_work, clk, rst_n, $rose(out_tvalid), !$past(in_tready), "output without fetch processing")

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (.*);

// ===== tb/sv/bilinear_image_scaler_tb.sv =====
module bilinear_image_scaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bis_pkg::*;

  localparam int ITEM_TARGET   = 1100;
  localparam int CALM_MARGIN   = 200;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int REPORT_LIMIT  = 10;

  // One output pixel as it leaves the block.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             frame_end;
  } scaled_pixel_t;

  // One line of the directed table: a register write or a request.
  typedef struct {
    bit                     is_cfg;
    logic [CFG_ADDR_W-1:0]  sel;
    logic [CFG_DATA_W-1:0]  value;
    logic                   op;
    logic [PIX_W-1:0]       pix;
    bit                     typed;
    scaled_pixel_t          want;
  } stim_row_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] src_w;
    logic [CFG_DATA_W-1:0] src_h;
    logic [CFG_DATA_W-1:0] dst_w;
    logic [CFG_DATA_W-1:0] dst_h;
  } frame_sizes_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [PIX_W-1:0]      out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bilinear_image_scaler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Shadow copy of the scaler state.
  logic [PIX_W-1:0]     frame_pixels [STORE_DEPTH];
  int unsigned          loaded_count;
  int unsigned          row_pos, col_pos, out_row, out_col;
  int unsigned          row_stride, col_stride;
  logic [SRC_CFG_W-1:0] src_w_reg, src_h_reg;
  logic [DST_CFG_W-1:0] dst_w_reg, dst_h_reg;

  scaled_pixel_t awaited_pixels [$];
  int            bad_results = 0;
  int            useful_items;
  bit            calm;
  bit            idle_on;
  bit            hold_request;
  bit            hold_used;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned frame_size();
    return clamp_size(src_w_reg, MAX_SRC_WIDTH) * clamp_size(src_h_reg, MAX_SRC_HEIGHT);
  endfunction

  // Applies one accepted request to the shadow state. acted is low when the
  // block ignores the request; produced is high when a pixel comes out.
  task automatic scale_request(input logic op, input logic [PIX_W-1:0] pix,
                               output bit acted, output bit produced,
                               output scaled_pixel_t res);
    int unsigned       sw, sh, dw, dh, r0, r1, c0, c1, rfrac, cfrac;
    longint unsigned   p00, p01, p10, p11, acc, t, val;
    bit                row_done, frame_done;
    acted = 1'b0;
    produced = 1'b0;
    res = '0;
    sw = clamp_size(src_w_reg, MAX_SRC_WIDTH);
    sh = clamp_size(src_h_reg, MAX_SRC_HEIGHT);
    dw = clamp_size(dst_w_reg, MAX_DST);
    dh = clamp_size(dst_h_reg, MAX_DST);

    if (op == OP_LOAD) begin
      if (loaded_count < sw * sh) begin
        frame_pixels[loaded_count] = pix;
        loaded_count++;
        acted = 1'b1;
      end
      return;
    end
    if (loaded_count < sw * sh) return;

    // Steps are latched at the first pixel of each output frame.
    if (out_row == 0 && out_col == 0) begin
      row_stride = (sh << FRAC_BITS) / dh;
      col_stride = (sw << FRAC_BITS) / dw;
      row_pos = 0;
      col_pos = 0;
    end

    r0 = row_pos >> FRAC_BITS;
    if (r0 > sh - 1) r0 = sh - 1;
    r1 = (r0 < sh - 1) ? r0 + 1 : r0;
    rfrac = row_pos & (FRAC_ONE - 1);
    c0 = col_pos >> FRAC_BITS;
    if (c0 > sw - 1) c0 = sw - 1;
    c1 = (c0 < sw - 1) ? c0 + 1 : c0;
    cfrac = col_pos & (FRAC_ONE - 1);

    p00 = frame_pixels[r0 * sw + c0];
    p10 = frame_pixels[r1 * sw + c0];
    p01 = frame_pixels[r0 * sw + c1];
    p11 = frame_pixels[r1 * sw + c1];

    // The right-hand pair only contributes when the column fraction is nonzero.
    acc = (p00 * (FRAC_ONE - rfrac) + p10 * rfrac) * (FRAC_ONE - cfrac);
    if (cfrac != 0) acc += (p01 * (FRAC_ONE - rfrac) + p11 * rfrac) * cfrac;

    // Round up only when the residual is strictly above one half.
    t = acc >> FRAC_BITS;
    val = t >> FRAC_BITS;
    if ((t & (FRAC_ONE - 1)) > FRAC_HALF) val++;
    if (val > 255) val = 255;

    row_done = (out_col + 1 >= dw);
    frame_done = row_done && (out_row + 1 >= dh);
    res.pixel = val[PIX_W-1:0];
    res.row_end = row_done;
    res.frame_end = frame_done;
    acted = 1'b1;
    produced = 1'b1;

    if (frame_done) begin
      loaded_count = 0;
      row_pos = 0;
      col_pos = 0;
      out_row = 0;
      out_col = 0;
    end else if (row_done) begin
      out_col = 0;
      col_pos = 0;
      out_row++;
      row_pos += row_stride;
    end else begin
      out_col++;
      col_pos += col_stride;
    end
  endtask

  // Offers one request, with an occasional gap in front, and waits for it to
  // be taken. The shadow state is updated at the accepting edge.
  task automatic issue_request(input logic op, input logic [PIX_W-1:0] pix,
                               output bit acted, output bit produced,
                               output scaled_pixel_t res);
    int gap;
    if (!calm && idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= pix;
    do @(posedge clk); while (in_tready !== 1'b1);
    scale_request(op, pix, acted, produced, res);
  endtask

  // Stops offering requests, waits for every pending pixel and lets the
  // pipeline run empty.
  task automatic drain_and_settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_ADDR_W-1:0] sel,
                            input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= sel;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (sel)
      CFG_SRC_WIDTH:  src_w_reg = value[SRC_CFG_W-1:0];
      CFG_SRC_HEIGHT: src_h_reg = value[SRC_CFG_W-1:0];
      CFG_DST_WIDTH:  dst_w_reg = value[DST_CFG_W-1:0];
      default:        dst_h_reg = value[DST_CFG_W-1:0];
    endcase
  endtask

  task automatic apply_sizes(input frame_sizes_t s);
    drain_and_settle();
    write_size(CFG_SRC_WIDTH, s.src_w);
    write_size(CFG_SRC_HEIGHT, s.src_h);
    write_size(CFG_DST_WIDTH, s.dst_w);
    write_size(CFG_DST_HEIGHT, s.dst_h);
  endtask

  function automatic stim_row_t cfg_row(logic [CFG_ADDR_W-1:0] sel,
                                        logic [CFG_DATA_W-1:0] value);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.sel = sel;
    r.value = value;
    return r;
  endfunction

  function automatic stim_row_t req_row(logic op, logic [PIX_W-1:0] pix);
    stim_row_t r;
    r = '{default: '0};
    r.op = op;
    r.pix = pix;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic op, logic [PIX_W-1:0] pix,
                                          scaled_pixel_t want);
    stim_row_t r;
    r = req_row(op, pix);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  // Source sizes: mostly small, sometimes zero, the maximum or above it.
  // Upper write-data bits are random since the register drops them.
  function automatic logic [CFG_DATA_W-1:0] pick_src();
    logic [SRC_CFG_W-1:0] v;
    case ($urandom_range(0, 11))
      0:       v = 8'd0;
      1:       v = 8'd128;
      2:       v = 8'd255;
      3:       v = 8'($urandom);
      default: v = 8'($urandom_range(1, 6));
    endcase
    return {3'($urandom), v};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dst();
    case ($urandom_range(0, 11))
      0:       return 11'd0;
      1:       return 11'd1024;
      2:       return 11'd2047;
      default: return 11'($urandom_range(1, 10));
    endcase
  endfunction

  // Frames that push every register to its extremes. Large output sizes are
  // cut short by a register change in the middle of the frame.
  function automatic frame_sizes_t corner_sizes(int n);
    case (n)
      0:       return '{11'd255, 11'd1, 11'd2047, 11'd1};
      1:       return '{11'd1, 11'd255, 11'd1, 11'd2047};
      2:       return '{11'd128, 11'd0, 11'd1024, 11'd0};
      default: return '{11'd0, 11'd128, 11'd0, 11'd1024};
    endcase
  endfunction

  // Loads one frame and fetches it out, with stray requests mixed in. At
  // shrink_at pixels the output sizes, and sometimes the source width, are rewritten.
  task automatic run_frame(input int shrink_at, input bit with_hold);
    int            fetched;
    bit            closed, acted, produced;
    logic          op;
    logic [PIX_W-1:0] pix;
    scaled_pixel_t res;
    fetched = 0;
    closed = 1'b0;
    while (!closed) begin
      op = (loaded_count < frame_size()) ? OP_LOAD : OP_FETCH;
      if (op == OP_FETCH && shrink_at != 0 && fetched == shrink_at) begin
        drain_and_settle();
        write_size(CFG_DST_WIDTH, 11'($urandom_range(1, 10)));
        write_size(CFG_DST_HEIGHT, 11'($urandom_range(1, 10)));
        if (frame_size() <= 64 && $urandom_range(0, 2) == 0)
          write_size(CFG_SRC_WIDTH, 11'($urandom_range(1, 8)));
        shrink_at = 0;
        continue;
      end
      // A load past a full frame or a fetch before one: ignored by the block.
      if ($urandom_range(0, 15) == 0) op = ~op;
      pix = 8'($urandom);
      if (with_hold && !hold_used && op == OP_FETCH && fetched == 1) begin
        hold_request = 1'b1;
        hold_used = 1'b1;
      end
      issue_request(op, pix, acted, produced, res);
      if (acted) useful_items++;
      if (produced) begin
        awaited_pixels.push_back(res);
        fetched++;
        closed = res.frame_end;
      end
    end
  endtask

  // Output checker.
  scaled_pixel_t seen_pixel, want_pixel;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_pixel = '{out_tdata, out_tlast, out_tuser};
      if (awaited_pixels.size() == 0) begin
        bad_results++;
        if (bad_results <= REPORT_LIMIT)
          $display("unexpected pixel %02h row_end %0b frame_end %0b, none pending",
                   seen_pixel.pixel, seen_pixel.row_end, seen_pixel.frame_end);
      end else begin
        want_pixel = awaited_pixels.pop_front();
        if (seen_pixel.pixel !== want_pixel.pixel ||
            seen_pixel.row_end !== want_pixel.row_end ||
            seen_pixel.frame_end !== want_pixel.frame_end) begin
          bad_results++;
          if (bad_results <= REPORT_LIMIT)
            $display("pixel mismatch: pixel exp %02h got %02h, row_end exp %0b got %0b, %s",
                     want_pixel.pixel, seen_pixel.pixel, want_pixel.row_end,
                     seen_pixel.row_end,
                     $sformatf("frame_end exp %0b got %0b",
                               want_pixel.frame_end, seen_pixel.frame_end));
        end
      end
    end
  end

  // Output back-pressure: random stall bursts, free-running stretches, and
  // one long hold-off on request from the sender.
  initial begin
    int low_left;
    int free_left;
    bit hold_taken;
    low_left = 0;
    free_left = 0;
    hold_taken = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        low_left = HOLD_CYCLES;
      end
      if (low_left > 0) begin
        out_tready <= 1'b0;
        low_left--;
      end else begin
        out_tready <= 1'b1;
        if (free_left > 0) free_left--;
        else if (!calm && $urandom_range(0, 5) == 0) low_left = $urandom_range(1, 16);
        else if ($urandom_range(0, 15) == 0) free_left = $urandom_range(20, 150);
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[bilinear_image_scaler] ERROR");
    $finish;
  end

  // Main sequence: directed table, then random frames.
  initial begin
    stim_row_t     steps [$];
    bit            acted, produced;
    scaled_pixel_t res;
    frame_sizes_t  sizes;
    int            frame_no, shrink_at, dst_cells;

    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_LOAD;
    cfg_we = 1'b0;
    cfg_addr = CFG_SRC_WIDTH;
    cfg_wdata = '0;
    rst_n = 1'b0;
    loaded_count = 0;
    row_pos = 0;
    col_pos = 0;
    out_row = 0;
    out_col = 0;
    row_stride = 0;
    col_stride = 0;
    src_w_reg = 8'd128;
    src_h_reg = 8'd128;
    dst_w_reg = 11'd128;
    dst_h_reg = 11'd128;
    useful_items = 0;
    calm = 1'b0;
    idle_on = 1'b1;
    hold_request = 1'b0;
    hold_used = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fetch before any frame is held: nothing comes out.
    steps.push_back(req_row(OP_FETCH, 8'hFF));
    // Zero sizes clamp to a 1x1 image; the extra load and the fetch after the
    // end of the frame are both ignored.
    steps.push_back(cfg_row(CFG_SRC_WIDTH, 11'd0));
    steps.push_back(cfg_row(CFG_SRC_HEIGHT, 11'd0));
    steps.push_back(cfg_row(CFG_DST_WIDTH, 11'd0));
    steps.push_back(cfg_row(CFG_DST_HEIGHT, 11'd0));
    steps.push_back(req_row(OP_LOAD, 8'hFF));
    steps.push_back(req_row(OP_LOAD, 8'h00));
    steps.push_back(typed_row(OP_FETCH, 8'h00, '{8'hFF, 1'b1, 1'b1}));
    steps.push_back(req_row(OP_FETCH, 8'hFF));
    // 2x1 to 4x1: a residual of exactly one half rounds down, and the last
    // column repeats past the edge.
    steps.push_back(cfg_row(CFG_SRC_WIDTH, 11'd2));
    steps.push_back(cfg_row(CFG_SRC_HEIGHT, 11'd1));
    steps.push_back(cfg_row(CFG_DST_WIDTH, 11'd4));
    steps.push_back(cfg_row(CFG_DST_HEIGHT, 11'd1));
    steps.push_back(req_row(OP_LOAD, 8'h00));
    steps.push_back(req_row(OP_LOAD, 8'hFF));
    repeat (4) steps.push_back(req_row(OP_FETCH, 8'h00));
    // 2x2 to 3x3: fractions in both directions, last row repeated.
    steps.push_back(cfg_row(CFG_SRC_HEIGHT, 11'd2));
    steps.push_back(cfg_row(CFG_DST_WIDTH, 11'd3));
    steps.push_back(cfg_row(CFG_DST_HEIGHT, 11'd3));
    steps.push_back(req_row(OP_LOAD, 8'h10));
    steps.push_back(req_row(OP_LOAD, 8'hF3));
    steps.push_back(req_row(OP_LOAD, 8'h7A));
    steps.push_back(req_row(OP_LOAD, 8'hFF));
    repeat (9) steps.push_back(req_row(OP_FETCH, 8'hA5));

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        drain_and_settle();
        write_size(steps[i].sel, steps[i].value);
      end else begin
        issue_request(steps[i].op, steps[i].pix, acted, produced, res);
        if (acted) useful_items++;
        if (steps[i].typed) awaited_pixels.push_back(steps[i].want);
        else if (produced) awaited_pixels.push_back(res);
      end
    end

    // Random frames: the corner sizes first, then mostly small images.
    frame_no = 0;
    while (useful_items < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 2) != 0);
      if (frame_no < 4 || $urandom_range(0, 2) != 0) begin
        if (frame_no < 4) begin
          sizes = corner_sizes(frame_no);
        end else begin
          sizes.src_w = pick_src();
          sizes.src_h = pick_src();
          sizes.dst_w = pick_dst();
          sizes.dst_h = pick_dst();
          if (clamp_size(sizes.src_w[7:0], MAX_SRC_WIDTH) *
              clamp_size(sizes.src_h[7:0], MAX_SRC_HEIGHT) > 256)
            sizes.src_h = {3'($urandom), 8'($urandom_range(0, 2))};
        end
        apply_sizes(sizes);
      end
      dst_cells = clamp_size(dst_w_reg, MAX_DST) * clamp_size(dst_h_reg, MAX_DST);
      if (dst_cells > 300) shrink_at = $urandom_range(30, 120);
      else if ($urandom_range(0, 5) == 0) shrink_at = $urandom_range(1, dst_cells);
      else shrink_at = 0;
      run_frame(shrink_at, frame_no == 0);
      frame_no++;
      if (useful_items >= ITEM_TARGET - CALM_MARGIN) calm = 1'b1;
    end

    drain_and_settle();
    if (bad_results == 0 && awaited_pixels.size() == 0) begin
      $display("[bilinear_image_scaler] OK");
    end else begin
      $display("[bilinear_image_scaler] ERROR");
    end
    $finish;
  end

endmodule
